@@ rtl/rgbyuv_pkg.sv @@
package rgbyuv_pkg;

	localparam logic DIR_RGB_TO_YUYV = 1'b0;
	localparam logic DIR_YUYV_TO_RGB = 1'b1;

	typedef struct packed {
		logic [7:0] in_red_first;
		logic [7:0] in_green_first;
		logic [7:0] in_blue_first;
		logic [7:0] in_red_second;
		logic [7:0] in_green_second;
		logic [7:0] in_blue_second;
		logic [7:0] in_luma_first;
		logic [7:0] in_chroma_u;
		logic [7:0] in_luma_second;
		logic [7:0] in_chroma_v;
		logic       in_frame_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_luma_first;
		logic [7:0] out_chroma_u;
		logic [7:0] out_luma_second;
		logic [7:0] out_chroma_v;
		logic [7:0] out_red_first;
		logic [7:0] out_green_first;
		logic [7:0] out_blue_first;
		logic [7:0] out_red_second;
		logic [7:0] out_green_second;
		logic [7:0] out_blue_second;
		logic       out_frame_end;
	} out_item_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_en_t;

	localparam logic [7:0] LUMA_MIN   = 8'd16;
	localparam logic [7:0] LUMA_MAX   = 8'd240;
	localparam logic [7:0] CHROMA_MIN = 8'd16;
	localparam logic [7:0] CHROMA_MAX = 8'd235;

	// Sum is non-negative; shift right by 8 to take the floor, offset and clamp.
	function automatic logic [7:0] luma_out(input logic [16:0] sum);
		logic [8:0] v;
		v = 9'(sum[16:8]) + 9'd16;
		if (v > 9'(LUMA_MAX))
			return LUMA_MAX;
		else if (v < 9'(LUMA_MIN))
			return LUMA_MIN;
		else
			return v[7:0];
	endfunction

	function automatic logic [7:0] chroma_out(input logic signed [16:0] sum);
		logic signed [9:0] v;
		v = 10'($signed(sum[16:8])) + 10'sd128;
		if (v > $signed({2'b00, CHROMA_MAX}))
			return CHROMA_MAX;
		else if (v < $signed({2'b00, CHROMA_MIN}))
			return CHROMA_MIN;
		else
			return v[7:0];
	endfunction

	function automatic logic [7:0] rgb_out(input logic signed [19:0] sum);
		logic signed [11:0] v;
		v = $signed(sum[19:8]);
		if (v < 12'sd0)
			return 8'd0;
		else if (v > 12'sd255)
			return 8'd255;
		else
			return v[7:0];
	endfunction

endpackage

@@ rtl/rgb24_yuyv_color_convert.sv @@
// RGB24 <-> YUYV 4:2:2 pixel-pair converter, BT.601 integer coefficients.
// Input channel: in_valid / in_stall with one pixel pair per item in in_item.
// Output channel: out_valid / out_stall with one result item in out_item.
// cfg_wr_en / cfg_wr_data set the direction: 0 converts RGB pairs to YUYV,
// 1 converts YUYV to RGB pairs. Change it only while no item is in flight.
// Fields of the unused direction read as zero; the frame-end mark follows
// its item.
// An accepted item passes the multiply, sum and clamp stages in turn to
// out_valid. Throughput: one item per cycle while out_stall is low; each
// of the three product/sum/clamp stages loads as the stage ahead moves.
// Reset clears all stage valid bits and sets the direction to RGB to YUYV.
// When the receiver stalls, the output item holds, the stages behind fill
// up, and in_stall rises once all three stages hold items.
module rgb24_yuyv_color_convert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rgbyuv_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rgbyuv_pkg::out_item_t out_item,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data
);
	import rgbyuv_pkg::*;

	pipe_en_t   en;
	logic       dir;
	logic       frame_end;
	logic [7:0] y0, u, y1, v;
	logic [7:0] r0, g0, b0, r1, g1, b1;
	logic       is_rgb;

	rgbyuv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_frame_end  (in_item.in_frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_frame_end (frame_end),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.dir           (dir),
		.en            (en)
	);

	rgbyuv_fwd u_fwd (
		.clk         (clk),
		.en          (en),
		.in_item     (in_item),
		.luma_first  (y0),
		.chroma_u    (u),
		.luma_second (y1),
		.chroma_v    (v)
	);

	rgbyuv_rev u_rev (
		.clk          (clk),
		.en           (en),
		.in_item      (in_item),
		.red_first    (r0),
		.green_first  (g0),
		.blue_first   (b0),
		.red_second   (r1),
		.green_second (g1),
		.blue_second  (b1)
	);

	assign is_rgb = (dir == DIR_YUYV_TO_RGB);

	always_comb begin
		out_item                  = '0;
		out_item.out_frame_end    = frame_end;
		if (is_rgb) begin
			out_item.out_red_first    = r0;
			out_item.out_green_first  = g0;
			out_item.out_blue_first   = b0;
			out_item.out_red_second   = r1;
			out_item.out_green_second = g1;
			out_item.out_blue_second  = b1;
		end else begin
			out_item.out_luma_first  = y0;
			out_item.out_chroma_u    = u;
			out_item.out_luma_second = y1;
			out_item.out_chroma_v    = v;
		end
	end

endmodule

@@ rtl/rgbyuv_ctrl.sv @@
module rgbyuv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                in_frame_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                out_frame_end,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output logic                dir,
	output rgbyuv_pkg::pipe_en_t en
);
	import rgbyuv_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic fe_s1, fe_s2, fe_s3;
	logic dir_q;
	logic adv1, adv2, adv3;

	assign adv3 = !valid_s3 || !out_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign en   = {adv1, adv2, adv3};

	assign in_stall      = !adv1;
	assign out_valid     = valid_s3;
	assign out_frame_end = fe_s3;
	assign dir           = dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			dir_q    <= DIR_RGB_TO_YUYV;
		end else begin
			if (en.en_s1)
				valid_s1 <= in_valid;
			if (en.en_s2)
				valid_s2 <= valid_s1;
			if (en.en_s3)
				valid_s3 <= valid_s2;
			if (cfg_wr_en)
				dir_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1)
			fe_s1 <= in_frame_end;
		if (en.en_s2)
			fe_s2 <= fe_s1;
		if (en.en_s3)
			fe_s3 <= fe_s2;
	end

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item did not enter stage 1");

	a_blocked_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en.en_s3 |=> valid_s2)
		else $error("stage 2 item lost while blocked");

	a_drain_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_stall && !valid_s2 |=> !valid_s3)
		else $error("delivered item repeated");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en.en_s2 |=> valid_s2)
		else $error("stage 1 item dropped on advance");

endmodule

@@ rtl/rgbyuv_fwd.sv @@
module rgbyuv_fwd (
	input  logic                 clk,
	input  rgbyuv_pkg::pipe_en_t en,
	input  rgbyuv_pkg::in_item_t in_item,
	output logic [7:0]           luma_first,
	output logic [7:0]           chroma_u,
	output logic [7:0]           luma_second,
	output logic [7:0]           chroma_v
);
	import rgbyuv_pkg::*;

	logic [15:0] y0r_s1, y0g_s1, y0b_s1;
	logic [15:0] y1r_s1, y1g_s1, y1b_s1;
	logic [15:0] ur_s1, ug_s1, ub_s1;
	logic [15:0] vr_s1, vg_s1, vb_s1;

	logic        [16:0] y0_s2, y1_s2;
	logic signed [16:0] u_s2, v_s2;

	logic [7:0] y0_s3, u_s3, y1_s3, v_s3;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			y0r_s1 <= 16'(in_item.in_red_first)    * 16'd66;
			y0g_s1 <= 16'(in_item.in_green_first)  * 16'd129;
			y0b_s1 <= 16'(in_item.in_blue_first)   * 16'd25;
			y1r_s1 <= 16'(in_item.in_red_second)   * 16'd66;
			y1g_s1 <= 16'(in_item.in_green_second) * 16'd129;
			y1b_s1 <= 16'(in_item.in_blue_second)  * 16'd25;
			ur_s1  <= 16'(in_item.in_red_first)    * 16'd38;
			ug_s1  <= 16'(in_item.in_green_first)  * 16'd74;
			ub_s1  <= 16'(in_item.in_blue_first)   * 16'd112;
			vr_s1  <= 16'(in_item.in_red_first)    * 16'd112;
			vg_s1  <= 16'(in_item.in_green_first)  * 16'd94;
			vb_s1  <= 16'(in_item.in_blue_first)   * 16'd18;
		end
		if (en.en_s2) begin
			y0_s2 <= 17'(y0r_s1) + 17'(y0g_s1) + 17'(y0b_s1);
			y1_s2 <= 17'(y1r_s1) + 17'(y1g_s1) + 17'(y1b_s1);
			u_s2  <= $signed({1'b0, ub_s1}) - $signed({1'b0, ur_s1})
				- $signed({1'b0, ug_s1});
			v_s2  <= $signed({1'b0, vr_s1}) - $signed({1'b0, vg_s1})
				- $signed({1'b0, vb_s1});
		end
		if (en.en_s3) begin
			y0_s3 <= luma_out(y0_s2);
			y1_s3 <= luma_out(y1_s2);
			u_s3  <= chroma_out(u_s2);
			v_s3  <= chroma_out(v_s2);
		end
	end

	assign luma_first  = y0_s3;
	assign chroma_u    = u_s3;
	assign luma_second = y1_s3;
	assign chroma_v    = v_s3;

endmodule

@@ rtl/rgbyuv_rev.sv @@
module rgbyuv_rev (
	input  logic                 clk,
	input  rgbyuv_pkg::pipe_en_t en,
	input  rgbyuv_pkg::in_item_t in_item,
	output logic [7:0]           red_first,
	output logic [7:0]           green_first,
	output logic [7:0]           blue_first,
	output logic [7:0]           red_second,
	output logic [7:0]           green_second,
	output logic [7:0]           blue_second
);
	import rgbyuv_pkg::*;

	logic signed [9:0] c0, c1, d, e;

	logic signed [19:0] c0p_s1, c1p_s1, er_s1, dg_s1, eg_s1, db_s1;
	logic signed [19:0] r0_s2, g0_s2, b0_s2, r1_s2, g1_s2, b1_s2;
	logic [7:0] r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;

	assign c0 = $signed({2'b00, in_item.in_luma_first})  - 10'sd16;
	assign c1 = $signed({2'b00, in_item.in_luma_second}) - 10'sd16;
	assign d  = $signed({2'b00, in_item.in_chroma_u})    - 10'sd128;
	assign e  = $signed({2'b00, in_item.in_chroma_v})    - 10'sd128;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			c0p_s1 <= 20'(c0) * 20'sd298;
			c1p_s1 <= 20'(c1) * 20'sd298;
			er_s1  <= 20'(e)  * 20'sd409;
			dg_s1  <= 20'(d)  * 20'sd100;
			eg_s1  <= 20'(e)  * 20'sd208;
			db_s1  <= 20'(d)  * 20'sd516;
		end
		if (en.en_s2) begin
			r0_s2 <= c0p_s1 + er_s1;
			g0_s2 <= c0p_s1 - dg_s1 - eg_s1;
			b0_s2 <= c0p_s1 + db_s1;
			r1_s2 <= c1p_s1 + er_s1;
			g1_s2 <= c1p_s1 - dg_s1 - eg_s1;
			b1_s2 <= c1p_s1 + db_s1;
		end
		if (en.en_s3) begin
			r0_s3 <= rgb_out(r0_s2);
			g0_s3 <= rgb_out(g0_s2);
			b0_s3 <= rgb_out(b0_s2);
			r1_s3 <= rgb_out(r1_s2);
			g1_s3 <= rgb_out(g1_s2);
			b1_s3 <= rgb_out(b1_s2);
		end
	end

	assign red_first    = r0_s3;
	assign green_first  = g0_s3;
	assign blue_first   = b0_s3;
	assign red_second   = r1_s3;
	assign green_second = g1_s3;
	assign blue_second  = b1_s3;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbyuv_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STEADY_FROM    = 1200;
	localparam int STEADY_TO      = 1800;
	localparam int IDLE_PERCENT   = 37;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 358;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_stall;
	in_item_t  in_item     = '0;
	logic      out_valid;
	logic      out_stall   = 1'b0;
	out_item_t out_item;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;

	in_item_t  pixel_queue[$];
	out_item_t converted_queue[$];

	logic        direction_copy = DIR_RGB_TO_YUYV;
	logic        in_taken       = 1'b0;
	logic        hold_input     = 1'b0;
	logic        steady;
	int unsigned cycle_count    = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned error_count    = 0;

	always #2 clk = ~clk;

	rgb24_yuyv_color_convert dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

	function automatic logic [7:0] clip(int v, int lo, int hi);
		if (v > hi)
			return 8'(hi);
		if (v < lo)
			return 8'(lo);
		return 8'(v);
	endfunction

	function automatic void yuv_to_rgb(input int c, input int d, input int e,
			output logic [7:0] red, output logic [7:0] green, output logic [7:0] blue);
		red   = clip((298 * c + 409 * e) >>> 8, 0, 255);
		green = clip((298 * c - 100 * d - 208 * e) >>> 8, 0, 255);
		blue  = clip((298 * c + 516 * d) >>> 8, 0, 255);
	endfunction

	function automatic out_item_t convert_pair(in_item_t p, logic dir);
		out_item_t r;
		int r0, g0, b0, r1, g1, b1;
		int y0, y1, d, e;
		r  = '0;
		r0 = p.in_red_first;
		g0 = p.in_green_first;
		b0 = p.in_blue_first;
		r1 = p.in_red_second;
		g1 = p.in_green_second;
		b1 = p.in_blue_second;
		y0 = int'(p.in_luma_first) - 16;
		d  = int'(p.in_chroma_u) - 128;
		y1 = int'(p.in_luma_second) - 16;
		e  = int'(p.in_chroma_v) - 128;
		if (dir == DIR_RGB_TO_YUYV) begin
			r.out_luma_first  = clip(((66 * r0 + 129 * g0 + 25 * b0) >>> 8) + 16, 16, 240);
			r.out_chroma_u    = clip(((-38 * r0 - 74 * g0 + 112 * b0) >>> 8) + 128, 16, 235);
			r.out_luma_second = clip(((66 * r1 + 129 * g1 + 25 * b1) >>> 8) + 16, 16, 240);
			r.out_chroma_v    = clip(((112 * r0 - 94 * g0 - 18 * b0) >>> 8) + 128, 16, 235);
		end else begin
			yuv_to_rgb(y0, d, e, r.out_red_first, r.out_green_first, r.out_blue_first);
			yuv_to_rgb(y1, d, e, r.out_red_second, r.out_green_second, r.out_blue_second);
		end
		r.out_frame_end = p.in_frame_end;
		return r;
	endfunction

	function automatic in_item_t random_pixels();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic logic [7:0] corner_byte();
		logic [7:0] corners[10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd127,
			8'd128, 8'd235, 8'd240, 8'd254, 8'd255};
		return corners[$urandom_range(9)];
	endfunction

	task automatic compare_field(string name, logic [7:0] expected, logic [7:0] actual);
		if (expected !== actual) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
			error_count++;
		end
	endtask

	task automatic check_result(out_item_t act);
		out_item_t exp;
		if (converted_queue.size() == 0) begin
			$display("%0t unexpected item: expected none, actual %h", $time, act);
			error_count++;
		end else begin
			exp = converted_queue.pop_front();
			compare_field("out_luma_first", exp.out_luma_first, act.out_luma_first);
			compare_field("out_chroma_u", exp.out_chroma_u, act.out_chroma_u);
			compare_field("out_luma_second", exp.out_luma_second, act.out_luma_second);
			compare_field("out_chroma_v", exp.out_chroma_v, act.out_chroma_v);
			compare_field("out_red_first", exp.out_red_first, act.out_red_first);
			compare_field("out_green_first", exp.out_green_first, act.out_green_first);
			compare_field("out_blue_first", exp.out_blue_first, act.out_blue_first);
			compare_field("out_red_second", exp.out_red_second, act.out_red_second);
			compare_field("out_green_second", exp.out_green_second, act.out_green_second);
			compare_field("out_blue_second", exp.out_blue_second, act.out_blue_second);
			compare_field("out_frame_end", 8'(exp.out_frame_end), 8'(act.out_frame_end));
		end
	endtask

	// driver: advance on acceptance, hold a stalled item
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pixel_queue.size() != 0 && !hold_input &&
					(steady || $urandom_range(99) >= IDLE_PERCENT)) begin
				in_item  <= pixel_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken    <= in_valid && !in_stall;
		if (cfg_wr_en)
			direction_copy <= cfg_wr_data;
		if (arst_n && in_valid && !in_stall)
			converted_queue.push_back(convert_pair(in_item, direction_copy));
		if (arst_n && out_valid && !out_stall)
			check_result(out_item);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic set_direction(logic dir);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= dir;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pixel_queue.size() != 0 || in_valid || converted_queue.size() != 0);
	endtask

	task automatic push_pixels(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d, logic [7:0] e, logic [7:0] f, logic frame_end, logic dir);
		in_item_t it;
		it = random_pixels();
		if (dir == DIR_RGB_TO_YUYV) begin
			it.in_red_first    = a;
			it.in_green_first  = b;
			it.in_blue_first   = c;
			it.in_red_second   = d;
			it.in_green_second = e;
			it.in_blue_second  = f;
		end else begin
			it.in_luma_first  = a;
			it.in_chroma_u    = b;
			it.in_luma_second = c;
			it.in_chroma_v    = d;
		end
		it.in_frame_end = frame_end;
		pixel_queue.push_back(it);
	endtask

	task automatic load_random(int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it = random_pixels();
			if ($urandom_range(4) == 0) begin
				it.in_red_first    = corner_byte();
				it.in_green_first  = corner_byte();
				it.in_blue_first   = corner_byte();
				it.in_red_second   = corner_byte();
				it.in_green_second = corner_byte();
				it.in_blue_second  = corner_byte();
				it.in_luma_first   = corner_byte();
				it.in_chroma_u     = corner_byte();
				it.in_luma_second  = corner_byte();
				it.in_chroma_v     = corner_byte();
			end
			pixel_queue.push_back(it);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		set_direction(DIR_RGB_TO_YUYV);
		push_pixels(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, DIR_RGB_TO_YUYV);
		push_pixels(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1, DIR_RGB_TO_YUYV);
		push_pixels(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, DIR_RGB_TO_YUYV);
		push_pixels(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, DIR_RGB_TO_YUYV);
		push_pixels(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 1'b0, DIR_RGB_TO_YUYV);
		push_pixels(8'd128, 8'd128, 8'd128, 8'd16, 8'd235, 8'd240, 1'b0, DIR_RGB_TO_YUYV);
		push_pixels(8'd1, 8'd2, 8'd3, 8'd254, 8'd253, 8'd252, 1'b1, DIR_RGB_TO_YUYV);
		drain();

		set_direction(DIR_YUYV_TO_RGB);
		push_pixels(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, DIR_YUYV_TO_RGB);
		push_pixels(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, DIR_YUYV_TO_RGB);
		push_pixels(8'd16, 8'd128, 8'd235, 8'd128, 8'd0, 8'd0, 1'b0, DIR_YUYV_TO_RGB);
		push_pixels(8'd255, 8'd128, 8'd0, 8'd128, 8'd0, 8'd0, 1'b1, DIR_YUYV_TO_RGB);
		push_pixels(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, DIR_YUYV_TO_RGB);
		push_pixels(8'd128, 8'd0, 8'd128, 8'd255, 8'd0, 8'd0, 1'b0, DIR_YUYV_TO_RGB);
		push_pixels(8'd16, 8'd16, 8'd240, 8'd240, 8'd0, 8'd0, 1'b1, DIR_YUYV_TO_RGB);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_direction((phase % 2 == 0) ? DIR_RGB_TO_YUYV : DIR_YUYV_TO_RGB);
			load_random(PHASE_ITEMS);
			if (phase == 2) begin
				// hold the sender until every pending result is out
				wait (pixel_queue.size() < PHASE_ITEMS / 2);
				@(posedge clk);
				hold_input = 1'b1;
				do
					@(posedge clk);
				while (in_valid || converted_queue.size() != 0);
				hold_input = 1'b0;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0 && converted_queue.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rgbyuv_pkg.sv
rtl/rgbyuv_ctrl.sv
rtl/rgbyuv_fwd.sv
rtl/rgbyuv_rev.sv
rtl/rgb24_yuyv_color_convert.sv
tb/sv/tb_top.sv
